FILE: rtl/mct_pkg.sv
// Package of the monitor command tokenizer: constants, codes and types.
`timescale 1ns / 1ps
package mct_pkg;

	// Text buffer geometry and the longest text a token may hold.
	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW    = 5;
	localparam int MAX_TEXT  = 32;
	localparam int CNT_W     = 6;
	localparam int PACK_MAX  = 8;

	// Token kinds.
	localparam logic [4:0] K_EOL    = 5'd0;
	localparam logic [4:0] K_BAD    = 5'd1;
	localparam logic [4:0] K_CONST  = 5'd2;
	localparam logic [4:0] K_STRING = 5'd3;
	localparam logic [4:0] K_WORD   = 5'd4;
	localparam logic [4:0] K_REG    = 5'd5;
	localparam logic [4:0] K_SINGLE = 5'd6;
	localparam logic [4:0] K_OP0    = 5'd7;
	localparam logic [4:0] K_MOD0   = 5'd18;

	typedef enum logic [3:0] {
		M_IDLE,
		M_OPER,
		M_WORD,
		M_QUOTE,
		M_QESC,
		M_QOCT
	} mct_mode_t;

	typedef enum logic [1:0] {
		B_DEC,
		B_OCT,
		B_HEX
	} mct_base_t;

	typedef enum logic [3:0] {
		ST_WAIT,
		ST_DISP,
		ST_QFIN,
		ST_PACK_RD,
		ST_PACK_EV,
		ST_RUN_RD,
		ST_RUN_EV,
		ST_W_R0,
		ST_W_R1,
		ST_W_R2,
		ST_W_CLS,
		ST_NUM_RD,
		ST_NUM_EV
	} mct_state_t;

	// Decisions of the datapath that steer the sequencer.
	typedef struct packed {
		logic hold;
		logic fin_quote;
		logic fin_word;
		logic start_pack;
		logic start_run;
		logic start_num;
		logic tok_done;
		logic redo;
	} mct_ctl_t;

endpackage

FILE: rtl/mct_if.sv
// Handshake interfaces for the character and token channels.
`timescale 1ns / 1ps
interface mct_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface mct_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  kind;
	logic [63:0] value;
	logic [7:0]  text_char;
	logic        last;

	modport source (output valid, output kind, output value, output text_char, output last,
		input ready);
	modport sink (input valid, input kind, input value, input text_char, input last,
		output ready);
endinterface

FILE: rtl/mct_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module mct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/monitor_command_tokenizer_core.sv
// Top level of the monitor command tokenizer: sequencer, text buffer and output register.
`timescale 1ns / 1ps
// The block takes one character of a command line per word on the cmd channel and
// gives tokens as words on the tok channel. A 0 character ends the line. Each token
// is one word with last set, except strings and words, which come out as a run of
// words, one text character each, the final one marked with last.
// An accepted character is registered and then worked on in the dispatch state; one that
// finishes no token lets cmd take the next one when the sequencer returns to waiting.
// Ending a token reads the 32-entry text buffer, which has one registered read port:
// a word costs three reads to classify; packing a character constant, parsing a number
// or sending a text run takes a read and an evaluate state per buffered character.
// All token state lives in registers and in the text buffer; only one character is
// in work at a time, and the character that ends a token may start another.
// After reset the block is at the start of a line with no token open; the buffer
// needs no clearing, as entries not written for the current token never decide a result.
// A single output register parts the channels: while tok stalls, work that would give
// another word waits, and a character that gives nothing still waits behind it.
module monitor_command_tokenizer_core (
	input  logic         clk,
	input  logic         arst_n,
	mct_cmd_if.sink      cmd,
	mct_tok_if.source    tok
);

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= "0") && (c <= "7");
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
			|| (c == "_");
	endfunction

	// Digit value, or 31 for a character that is no digit in any base.
	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd31;
		if (is_digit(c)) begin
			t = c - 8'h30;
		end else if ((c >= "a") && (c <= "f")) begin
			t = c - 8'h57;
		end else if ((c >= "A") && (c <= "F")) begin
			t = c - 8'h37;
		end
		return t[4:0];
	endfunction

	function automatic logic is_op_first(input logic [7:0] c);
		return (c == "<") || (c == ">") || (c == "=") || (c == "!") || (c == "+")
			|| (c == "-") || (c == "&") || (c == "|") || (c == "$");
	endfunction

	// Two-character operator: hit flag and kind.
	function automatic logic [5:0] op_kind(input logic [7:0] h, input logic [7:0] c);
		logic [5:0] r;
		r = {1'b0, mct_pkg::K_BAD};
		if (h == "<" && c == "<") r = {1'b1, mct_pkg::K_OP0 + 5'd0};
		else if (h == "<" && c == "=") r = {1'b1, mct_pkg::K_OP0 + 5'd1};
		else if (h == ">" && c == ">") r = {1'b1, mct_pkg::K_OP0 + 5'd2};
		else if (h == ">" && c == "=") r = {1'b1, mct_pkg::K_OP0 + 5'd3};
		else if (h == "=" && c == "=") r = {1'b1, mct_pkg::K_OP0 + 5'd4};
		else if (h == "!" && c == "=") r = {1'b1, mct_pkg::K_OP0 + 5'd5};
		else if (h == "+" && c == "+") r = {1'b1, mct_pkg::K_OP0 + 5'd6};
		else if (h == "-" && c == "-") r = {1'b1, mct_pkg::K_OP0 + 5'd7};
		else if (h == "&" && c == "&") r = {1'b1, mct_pkg::K_OP0 + 5'd8};
		else if (h == "|" && c == "|") r = {1'b1, mct_pkg::K_OP0 + 5'd9};
		else if (h == "$" && c == "f") r = {1'b1, mct_pkg::K_OP0 + 5'd10};
		return r;
	endfunction

	function automatic logic [4:0] mod_kind(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			"h": r = mct_pkg::K_MOD0 + 5'd0;
			"i": r = mct_pkg::K_MOD0 + 5'd1;
			"m": r = mct_pkg::K_MOD0 + 5'd2;
			"u": r = mct_pkg::K_MOD0 + 5'd3;
			"c": r = mct_pkg::K_MOD0 + 5'd4;
			"p": r = mct_pkg::K_MOD0 + 5'd5;
			"s": r = mct_pkg::K_MOD0 + 5'd6;
			"n": r = mct_pkg::K_MOD0 + 5'd7;
			"w": r = mct_pkg::K_MOD0 + 5'd8;
			"b": r = mct_pkg::K_MOD0 + 5'd9;
			"L": r = mct_pkg::K_MOD0 + 5'd10;
			"H": r = mct_pkg::K_MOD0 + 5'd11;
			"P": r = mct_pkg::K_MOD0 + 5'd12;
			"E": r = mct_pkg::K_MOD0 + 5'd13;
			default: r = mct_pkg::K_BAD;
		endcase
		return r;
	endfunction

	// MIPS register name: valid flag and number.
	function automatic logic [6:0] reg_number(input logic [5:0] n, input logic [7:0] a,
		input logic [7:0] b_raw, input logic [7:0] c_raw);
		logic [7:0] b;
		logic [7:0] c;
		logic       two;
		logic       three;
		logic [7:0] bd;
		logic [7:0] cd;
		logic [7:0] v;
		logic [6:0] r;
		b     = (n > 6'd1) ? b_raw : 8'd0;
		c     = (n > 6'd2) ? c_raw : 8'd0;
		two   = (n == 6'd2);
		three = (n == 6'd3);
		bd    = b - 8'h30;
		cd    = c - 8'h30;
		v     = 8'd0;
		r     = 7'd0;
		case (a)
			"A": if (b == "T" && two) r = {1'b1, 6'd1};
			"v": if (b >= "0" && b <= "1" && two) r = {1'b1, bd[5:0] + 6'd2};
			"a": begin
				if (b >= "0" && b <= "7" && two) r = {1'b1, bd[5:0] + 6'd4};
				else if (b == "t" && two) r = {1'b1, 6'd1};
			end
			"t": begin
				if (b == "a" && c >= "0" && c <= "3" && three) r = {1'b1, cd[5:0] + 6'd8};
				else if (b >= "0" && b <= "3" && two) r = {1'b1, bd[5:0] + 6'd12};
				else if (b >= "8" && b <= "9" && two) r = {1'b1, bd[5:0] + 6'd16};
			end
			"s": begin
				if (b >= "0" && b <= "7" && two) r = {1'b1, bd[5:0] + 6'd16};
				else if (b == "p" && two) r = {1'b1, 6'd29};
				else if (b == "8" && two) r = {1'b1, 6'd30};
			end
			"j": if (b == "p" && two) r = {1'b1, 6'd25};
			"k": if (b >= "0" && b <= "1" && two) r = {1'b1, bd[5:0] + 6'd26};
			"g": if (b == "p" && two) r = {1'b1, 6'd28};
			"f": if (b == "p" && two) r = {1'b1, 6'd30};
			"r": begin
				v = bd * 8'd10 + cd;
				if (b == "a" && two) r = {1'b1, 6'd31};
				else if (is_digit(b) && two) r = {1'b1, bd[5:0]};
				else if (is_digit(b) && is_digit(c) && three && v < 8'd32) r = {1'b1, v[5:0]};
			end
			"p": if (b == "c" && two) r = {1'b1, 6'd32};
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	localparam logic [mct_pkg::CNT_W-1:0] MAXT = mct_pkg::CNT_W'(mct_pkg::MAX_TEXT);
	localparam logic [mct_pkg::CNT_W-1:0] PMAX = mct_pkg::CNT_W'(mct_pkg::PACK_MAX);

	mct_pkg::mct_state_t state_q, state_d;
	mct_pkg::mct_mode_t  mode_q, mode_d;
	mct_pkg::mct_base_t  base_q, base_d;
	mct_pkg::mct_ctl_t   ctl;

	logic [7:0]                  ch_q;
	logic [mct_pkg::CNT_W-1:0]   count_q, count_d;
	logic [mct_pkg::CNT_W-1:0]   idx_q, idx_d;
	logic                        quote_q, quote_d;
	logic [1:0]                  digits_q, digits_d;
	logic [8:0]                  oct_q, oct_d;
	logic [7:0]                  held_q, held_d;
	logic                        skip_q, skip_d;
	logic                        redo_q;
	logic [63:0]                 acc_q, acc_d;
	logic                        sat_q, sat_d;
	logic [7:0]                  prev_q, prev_d;
	logic [4:0]                  run_kind_q, run_kind_d;
	logic [7:0]                  b0_q;
	logic [7:0]                  b1_q;

	logic                        out_valid_q;
	logic [4:0]                  kind_q;
	logic [63:0]                 value_q;
	logic [7:0]                  text_q;
	logic                        last_q;

	logic                        out_free;
	logic                        emit;
	logic [4:0]                  e_kind;
	logic [63:0]                 e_value;
	logic [7:0]                  e_text;
	logic                        e_last;

	logic                        we;
	logic [mct_pkg::BUF_AW-1:0]  waddr;
	logic [7:0]                  wdata;
	logic                        re;
	logic [mct_pkg::BUF_AW-1:0]  raddr;
	logic [7:0]                  rdata;

	logic                        accept;
	logic [mct_pkg::CNT_W-1:0]   cnt_inc;
	logic [5:0]                  op_r;
	logic [6:0]                  reg_r;
	logic [4:0]                  dval;
	logic [4:0]                  base_num;
	logic [67:0]                 prod;
	logic [63:0]                 vfin;
	logic [63:0]                 packed_v;
	logic [8:0]                  oct_next;
	logic [7:0]                  esc_byte;
	logic [7:0]                  close_ch;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == mct_pkg::ST_WAIT);
	assign out_free  = !out_valid_q || tok.ready;

	assign tok.valid     = out_valid_q;
	assign tok.kind      = kind_q;
	assign tok.value     = value_q;
	assign tok.text_char = text_q;
	assign tok.last      = last_q;

	mct_ram #(
		.WIDTH (8),
		.DEPTH (mct_pkg::BUF_DEPTH)
	) u_text_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cnt_inc  = count_q + 1'b1;
	assign op_r     = op_kind(held_q, ch_q);
	assign reg_r    = reg_number(count_q, b0_q, b1_q, rdata);
	assign dval     = digit_val(rdata);
	assign oct_next = {oct_q[5:0], 3'b000} + {6'd0, ch_q[2:0]};
	assign close_ch = quote_q ? 8'h27 : 8'h22;
	assign packed_v = {acc_q[55:0], rdata};
	assign vfin     = sat_q ? {64{1'b1}} : acc_q;

	always_comb begin
		case (base_q)
			mct_pkg::B_HEX: base_num = 5'd16;
			mct_pkg::B_OCT: base_num = 5'd8;
			default:        base_num = 5'd10;
		endcase
	end

	always_comb begin
		case (base_q)
			mct_pkg::B_HEX: prod = {acc_q, 4'b0000} + {63'd0, dval};
			mct_pkg::B_OCT: prod = {1'b0, acc_q, 3'b000} + {63'd0, dval};
			default:        prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
				+ {63'd0, dval};
		endcase
	end

	always_comb begin
		case (ch_q)
			"b":     esc_byte = 8'd8;
			"t":     esc_byte = 8'd9;
			"n":     esc_byte = 8'd10;
			"f":     esc_byte = 8'd12;
			"r":     esc_byte = 8'd13;
			default: esc_byte = ch_q;
		endcase
	end

	// Datapath: what the current state does to the token state and the output.
	always_comb begin
		ctl        = '0;
		emit       = 1'b0;
		e_kind     = mct_pkg::K_EOL;
		e_value    = 64'd0;
		e_text     = 8'd0;
		e_last     = 1'b1;
		we         = 1'b0;
		waddr      = count_q[mct_pkg::BUF_AW-1:0];
		wdata      = ch_q;
		re         = 1'b0;
		raddr      = idx_q[mct_pkg::BUF_AW-1:0];
		mode_d     = mode_q;
		count_d    = count_q;
		idx_d      = idx_q;
		quote_d    = quote_q;
		digits_d   = digits_q;
		oct_d      = oct_q;
		held_d     = held_q;
		skip_d     = skip_q;
		acc_d      = acc_q;
		sat_d      = sat_q;
		base_d     = base_q;
		prev_d     = prev_q;
		run_kind_d = run_kind_q;

		case (state_q)
			mct_pkg::ST_DISP: begin
				if (!out_free) begin
					ctl.hold = 1'b1;
				end else begin
					case (mode_q)
						mct_pkg::M_OPER: begin
							mode_d = mct_pkg::M_IDLE;
							emit   = 1'b1;
							if (op_r[5]) begin
								e_kind = op_r[4:0];
							end else begin
								e_kind   = mct_pkg::K_SINGLE;
								e_value  = {56'd0, held_q};
								ctl.redo = 1'b1;
							end
						end
						mct_pkg::M_WORD: begin
							if (is_word_char(ch_q)) begin
								we      = 1'b1;
								count_d = cnt_inc;
								if (cnt_inc >= MAXT) begin
									emit   = 1'b1;
									e_kind = mct_pkg::K_BAD;
									skip_d = 1'b1;
									mode_d = mct_pkg::M_IDLE;
								end
							end else begin
								mode_d       = mct_pkg::M_IDLE;
								ctl.fin_word = 1'b1;
								ctl.redo     = !(count_q == 6'd1 && ch_q == ":");
							end
						end
						mct_pkg::M_QUOTE: begin
							if (ch_q == 8'd0) begin
								mode_d        = mct_pkg::M_IDLE;
								ctl.fin_quote = 1'b1;
								ctl.redo      = 1'b1;
							end else if (ch_q == close_ch) begin
								mode_d        = mct_pkg::M_IDLE;
								ctl.fin_quote = 1'b1;
							end else if (ch_q == 8'h5c) begin
								mode_d = mct_pkg::M_QESC;
							end else begin
								we      = 1'b1;
								count_d = cnt_inc;
								if (cnt_inc >= MAXT) begin
									mode_d        = mct_pkg::M_IDLE;
									ctl.fin_quote = 1'b1;
								end
							end
						end
						mct_pkg::M_QESC: begin
							mode_d = mct_pkg::M_QUOTE;
							if (ch_q == 8'd0) begin
								// A trailing backslash stores a 0 byte, then the line ends.
								we            = 1'b1;
								wdata         = 8'd0;
								count_d       = cnt_inc;
								mode_d        = mct_pkg::M_IDLE;
								ctl.fin_quote = 1'b1;
								ctl.redo      = 1'b1;
							end else if (is_oct(ch_q)) begin
								oct_d    = {6'd0, ch_q[2:0]};
								digits_d = 2'd1;
								mode_d   = mct_pkg::M_QOCT;
							end else begin
								we      = 1'b1;
								wdata   = esc_byte;
								count_d = cnt_inc;
								if (cnt_inc >= MAXT) begin
									mode_d        = mct_pkg::M_IDLE;
									ctl.fin_quote = 1'b1;
								end
							end
						end
						mct_pkg::M_QOCT: begin
							mode_d = mct_pkg::M_QUOTE;
							if (is_oct(ch_q) && digits_q < 2'd3) begin
								oct_d    = oct_next;
								digits_d = digits_q + 1'b1;
								if (digits_q + 1'b1 >= 2'd3) begin
									we      = 1'b1;
									wdata   = oct_next[7:0];
									count_d = cnt_inc;
									if (cnt_inc >= MAXT) begin
										mode_d        = mct_pkg::M_IDLE;
										ctl.fin_quote = 1'b1;
									end
								end else begin
									mode_d = mct_pkg::M_QOCT;
								end
							end else begin
								we       = 1'b1;
								wdata    = oct_q[7:0];
								count_d  = cnt_inc;
								ctl.redo = 1'b1;
								if (cnt_inc >= MAXT) begin
									mode_d        = mct_pkg::M_IDLE;
									ctl.fin_quote = 1'b1;
								end
							end
						end
						default: begin
							mode_d = mct_pkg::M_IDLE;
							if (skip_q) begin
								if (ch_q == 8'd0) begin
									skip_d = 1'b0;
								end
							end else if (ch_q == " " || ch_q == 8'd9 || ch_q == 8'd10) begin
								mode_d = mct_pkg::M_IDLE;
							end else if (ch_q == 8'd0) begin
								emit = 1'b1;
							end else if (ch_q == "#") begin
								emit   = 1'b1;
								skip_d = 1'b1;
							end else if (ch_q == 8'h22 || ch_q == 8'h27) begin
								mode_d  = mct_pkg::M_QUOTE;
								quote_d = (ch_q == 8'h27);
								count_d = '0;
							end else if (is_op_first(ch_q)) begin
								held_d = ch_q;
								mode_d = mct_pkg::M_OPER;
							end else if (is_word_char(ch_q)) begin
								we      = 1'b1;
								waddr   = '0;
								count_d = 6'd1;
								mode_d  = mct_pkg::M_WORD;
							end else begin
								emit    = 1'b1;
								e_kind  = mct_pkg::K_SINGLE;
								e_value = {56'd0, ch_q};
							end
						end
					endcase
				end
			end
			mct_pkg::ST_QFIN: begin
				idx_d = '0;
				acc_d = 64'd0;
				if (quote_q && count_q > PMAX) begin
					ctl.hold     = !out_free;
					emit         = out_free;
					e_kind       = mct_pkg::K_BAD;
					ctl.tok_done = out_free;
				end else if (quote_q && count_q == '0) begin
					ctl.hold     = !out_free;
					emit         = out_free;
					e_kind       = mct_pkg::K_CONST;
					ctl.tok_done = out_free;
				end else if (quote_q) begin
					ctl.start_pack = 1'b1;
				end else if (count_q >= MAXT) begin
					ctl.hold     = !out_free;
					emit         = out_free;
					e_kind       = mct_pkg::K_BAD;
					ctl.tok_done = out_free;
				end else begin
					run_kind_d    = mct_pkg::K_STRING;
					ctl.start_run = 1'b1;
				end
			end
			mct_pkg::ST_PACK_RD: begin
				re = 1'b1;
			end
			mct_pkg::ST_PACK_EV: begin
				if (idx_q + 1'b1 == count_q) begin
					ctl.hold     = !out_free;
					emit         = out_free;
					e_kind       = mct_pkg::K_CONST;
					e_value      = packed_v;
					ctl.tok_done = out_free;
				end else begin
					acc_d = packed_v;
					idx_d = idx_q + 1'b1;
				end
			end
			mct_pkg::ST_RUN_RD: begin
				re = 1'b1;
			end
			mct_pkg::ST_RUN_EV: begin
				e_kind = run_kind_q;
				if (idx_q == count_q || rdata == 8'd0) begin
					ctl.hold     = !out_free;
					emit         = out_free;
					e_text       = (idx_q == '0) ? 8'd0 : prev_q;
					ctl.tok_done = out_free;
				end else if (idx_q != '0 && !out_free) begin
					ctl.hold = 1'b1;
				end else begin
					emit   = (idx_q != '0);
					e_text = prev_q;
					e_last = 1'b0;
					prev_d = rdata;
					idx_d  = idx_q + 1'b1;
				end
			end
			mct_pkg::ST_W_R0: begin
				re    = 1'b1;
				raddr = '0;
			end
			mct_pkg::ST_W_R1: begin
				re    = 1'b1;
				raddr = mct_pkg::BUF_AW'(1);
			end
			mct_pkg::ST_W_R2: begin
				re    = 1'b1;
				raddr = mct_pkg::BUF_AW'(2);
			end
			mct_pkg::ST_W_CLS: begin
				idx_d = '0;
				acc_d = 64'd0;
				sat_d = 1'b0;
				if (count_q == 6'd1 && ch_q == ":") begin
					ctl.hold     = !out_free;
					emit         = out_free;
					e_kind       = mod_kind(b0_q);
					ctl.tok_done = out_free;
				end else if (is_digit(b0_q)) begin
					ctl.start_num = 1'b1;
					base_d        = mct_pkg::B_DEC;
					if (b0_q == "0") begin
						if (count_q >= 6'd3 && (b1_q == "x" || b1_q == "X")
							&& digit_val(rdata) < 5'd16) begin
							base_d = mct_pkg::B_HEX;
							idx_d  = mct_pkg::CNT_W'(2);
						end else begin
							base_d = mct_pkg::B_OCT;
						end
					end
				end else if (reg_r[6]) begin
					ctl.hold     = !out_free;
					emit         = out_free;
					e_kind       = mct_pkg::K_REG;
					e_value      = {58'd0, reg_r[5:0]};
					ctl.tok_done = out_free;
				end else begin
					run_kind_d    = mct_pkg::K_WORD;
					ctl.start_run = 1'b1;
				end
			end
			mct_pkg::ST_NUM_RD: begin
				re = 1'b1;
			end
			mct_pkg::ST_NUM_EV: begin
				if (idx_q == count_q) begin
					ctl.hold     = !out_free;
					emit         = out_free;
					e_kind       = mct_pkg::K_CONST;
					e_value      = vfin;
					ctl.tok_done = out_free;
				end else if (dval < base_num) begin
					idx_d = idx_q + 1'b1;
					if (!sat_q) begin
						if (prod[67:64] != 4'd0) begin
							sat_d = 1'b1;
						end else begin
							acc_d = prod[63:0];
						end
					end
				end else begin
					ctl.hold     = !out_free;
					emit         = out_free;
					ctl.tok_done = out_free;
					e_kind       = (idx_q + 1'b1 == count_q) ? mct_pkg::K_CONST : mct_pkg::K_BAD;
					if (rdata == "G" || rdata == "g") begin
						e_value = vfin << 30;
					end else if (rdata == "M" || rdata == "m") begin
						e_value = vfin << 20;
					end else if (rdata == "K" || rdata == "k") begin
						e_value = vfin << 10;
					end else begin
						e_kind = mct_pkg::K_BAD;
					end
					if (e_kind == mct_pkg::K_BAD) begin
						e_value = 64'd0;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mct_pkg::ST_WAIT: begin
				if (accept) state_d = mct_pkg::ST_DISP;
			end
			mct_pkg::ST_DISP: begin
				if (ctl.hold) state_d = mct_pkg::ST_DISP;
				else if (ctl.fin_quote) state_d = mct_pkg::ST_QFIN;
				else if (ctl.fin_word) state_d = mct_pkg::ST_W_R0;
				else if (ctl.redo) state_d = mct_pkg::ST_DISP;
				else state_d = mct_pkg::ST_WAIT;
			end
			mct_pkg::ST_QFIN: begin
				if (ctl.start_pack) state_d = mct_pkg::ST_PACK_RD;
				else if (ctl.start_run) state_d = mct_pkg::ST_RUN_RD;
				else if (ctl.tok_done) state_d = redo_q ? mct_pkg::ST_DISP : mct_pkg::ST_WAIT;
			end
			mct_pkg::ST_PACK_RD: state_d = mct_pkg::ST_PACK_EV;
			mct_pkg::ST_PACK_EV: begin
				if (ctl.tok_done) state_d = redo_q ? mct_pkg::ST_DISP : mct_pkg::ST_WAIT;
				else if (!ctl.hold) state_d = mct_pkg::ST_PACK_RD;
			end
			mct_pkg::ST_RUN_RD: state_d = mct_pkg::ST_RUN_EV;
			mct_pkg::ST_RUN_EV: begin
				if (ctl.tok_done) state_d = redo_q ? mct_pkg::ST_DISP : mct_pkg::ST_WAIT;
				else if (!ctl.hold) state_d = mct_pkg::ST_RUN_RD;
			end
			mct_pkg::ST_W_R0: state_d = mct_pkg::ST_W_R1;
			mct_pkg::ST_W_R1: state_d = mct_pkg::ST_W_R2;
			mct_pkg::ST_W_R2: state_d = mct_pkg::ST_W_CLS;
			mct_pkg::ST_W_CLS: begin
				if (ctl.start_num) state_d = mct_pkg::ST_NUM_RD;
				else if (ctl.start_run) state_d = mct_pkg::ST_RUN_RD;
				else if (ctl.tok_done) state_d = redo_q ? mct_pkg::ST_DISP : mct_pkg::ST_WAIT;
			end
			mct_pkg::ST_NUM_RD: state_d = mct_pkg::ST_NUM_EV;
			mct_pkg::ST_NUM_EV: begin
				if (ctl.tok_done) state_d = redo_q ? mct_pkg::ST_DISP : mct_pkg::ST_WAIT;
				else if (!ctl.hold) state_d = mct_pkg::ST_NUM_RD;
			end
			default: state_d = mct_pkg::ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mct_pkg::ST_WAIT;
			mode_q      <= mct_pkg::M_IDLE;
			base_q      <= mct_pkg::B_DEC;
			count_q     <= '0;
			idx_q       <= '0;
			quote_q     <= 1'b0;
			digits_q    <= 2'd0;
			oct_q       <= 9'd0;
			held_q      <= 8'd0;
			skip_q      <= 1'b0;
			redo_q      <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			base_q   <= base_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			quote_q  <= quote_d;
			digits_q <= digits_d;
			oct_q    <= oct_d;
			held_q   <= held_d;
			skip_q   <= skip_d;
			sat_q    <= sat_d;
			if (state_q == mct_pkg::ST_DISP && !ctl.hold) begin
				redo_q <= ctl.redo;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (tok.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= cmd.ch;
		end
		acc_q      <= acc_d;
		prev_q     <= prev_d;
		run_kind_q <= run_kind_d;
		if (state_q == mct_pkg::ST_W_R1) begin
			b0_q <= rdata;
		end
		if (state_q == mct_pkg::ST_W_R2) begin
			b1_q <= rdata;
		end
		if (emit) begin
			kind_q  <= e_kind;
			value_q <= e_value;
			text_q  <= e_text;
			last_q  <= e_last;
		end
	end

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n) emit |-> out_free)
		else $error("token word produced while the output register is occupied");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) count_q <= MAXT)
		else $error("text count beyond the longest text");
	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == mct_pkg::ST_DISP)
		else $error("accepted character not dispatched");
	a_text_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != mct_pkg::K_STRING && kind_q != mct_pkg::K_WORD)
		|-> (text_q == 8'd0 && last_q))
		else $error("non-text token carries text or an open run");
endmodule

FILE: bench/mct_token_checker.sv
// Checker of the tokenizer: predicts the token words for each accepted character and compares.
`timescale 1ns / 1ps
module mct_token_checker (
	input  logic  clk,
	input  logic  arst_n,
	mct_cmd_if    cmd,
	mct_tok_if    tok,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		logic [4:0]  kind;
		logic [63:0] value;
		logic [7:0]  text_char;
		logic        last;
	} token_word_t;

	localparam int    MAX_WORDS  = 34;
	localparam string OPER_PAIRS = "<<<=>>>===!=++--&&||$f";
	localparam string MOD_CHARS  = "himucpsnwbLHPE";

	token_word_t          token_q[$];
	mct_pkg::mct_mode_t   lex_mode;
	logic [7:0]           text_buf [mct_pkg::BUF_DEPTH];
	int                   text_len;
	bit                   in_char_const;
	int                   oct_digits;
	logic [8:0]           oct_val;
	logic [7:0]           held_ch;
	bit                   swallow_line;
	int                   words_this_char;

	function automatic bit is_dec(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_word_ch(logic [7:0] c);
		return is_dec(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic int digit_of(logic [7:0] c);
		if (is_dec(c)) return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 99;
	endfunction

	function automatic void push_token(logic [4:0] kind, logic [63:0] value, logic [7:0] tc,
		logic last);
		token_word_t w;
		if (words_this_char >= MAX_WORDS) return;
		w.kind = kind;
		w.value = value;
		w.text_char = tc;
		w.last = last;
		token_q.push_back(w);
		words_this_char++;
	endfunction

	function automatic void push_text_run(logic [4:0] kind, int n);
		if (n == 0) begin
			push_token(kind, 64'd0, 8'd0, 1'b1);
			return;
		end
		for (int k = 0; k < n; k++)
			push_token(kind, 64'd0, text_buf[k % mct_pkg::BUF_DEPTH], k + 1 == n);
	endfunction

	function automatic void close_quote();
		logic [63:0] v;
		int k;
		v = '0;
		lex_mode = mct_pkg::M_IDLE;
		if (in_char_const) begin
			if (text_len > mct_pkg::PACK_MAX) begin
				push_token(mct_pkg::K_BAD, 64'd0, 8'd0, 1'b1);
				return;
			end
			for (k = 0; k < text_len; k++)
				v = (v << 8) | 64'(text_buf[k]);
			push_token(mct_pkg::K_CONST, v, 8'd0, 1'b1);
		end else begin
			if (text_len >= mct_pkg::MAX_TEXT) begin
				push_token(mct_pkg::K_BAD, 64'd0, 8'd0, 1'b1);
				return;
			end
			for (k = 0; k < text_len; k++)
				if (text_buf[k] == 8'd0) break;
			push_text_run(mct_pkg::K_STRING, k);
		end
	endfunction

	function automatic bit store_text(logic [7:0] b);
		text_buf[text_len % mct_pkg::BUF_DEPTH] = b;
		text_len++;
		if (text_len >= mct_pkg::MAX_TEXT) begin
			close_quote();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void push_number(int n);
		logic [63:0] v, base, d;
		int pos;
		bit sat;
		logic [7:0] c;
		v = '0;
		base = 64'd10;
		pos = 0;
		sat = 0;
		if (text_buf[0] == "0") begin
			if (n >= 3 && (text_buf[1] == "x" || text_buf[1] == "X")
				&& digit_of(text_buf[2]) < 16) begin
				base = 64'd16;
				pos = 2;
			end else begin
				base = 64'd8;
			end
		end
		while (pos < n) begin
			d = 64'(digit_of(text_buf[pos % mct_pkg::BUF_DEPTH]));
			if (d >= base) break;
			if (!sat) begin
				if (v > ({64{1'b1}} - d) / base) sat = 1;
				else v = v * base + d;
			end
			pos++;
		end
		if (sat) v = '1;
		if (pos < n) begin
			c = text_buf[pos % mct_pkg::BUF_DEPTH];
			if (c == "G" || c == "g") begin
				v = v << 30;
				pos++;
			end else if (c == "M" || c == "m") begin
				v = v << 20;
				pos++;
			end else if (c == "K" || c == "k") begin
				v = v << 10;
				pos++;
			end
		end
		if (pos == n) push_token(mct_pkg::K_CONST, v, 8'd0, 1'b1);
		else push_token(mct_pkg::K_BAD, 64'd0, 8'd0, 1'b1);
	endfunction

	function automatic int mips_reg(int n);
		logic [7:0] a, b, c;
		bit two;
		int v;
		a = text_buf[0];
		b = n > 1 ? text_buf[1] : 8'd0;
		c = n > 2 ? text_buf[2] : 8'd0;
		two = (n == 2);
		case (a)
			"A": if (b == "T" && two) return 1;
			"v": if (b >= "0" && b <= "1" && two) return b - "0" + 2;
			"a": begin
				if (b >= "0" && b <= "7" && two) return b - "0" + 4;
				if (b == "t" && two) return 1;
			end
			"t": begin
				if (b == "a" && c >= "0" && c <= "3" && n == 3) return c - "0" + 8;
				if (b >= "0" && b <= "3" && two) return b - "0" + 12;
				if (b >= "8" && b <= "9" && two) return b - "8" + 24;
			end
			"s": begin
				if (b >= "0" && b <= "7" && two) return b - "0" + 16;
				if (b == "p" && two) return 29;
				if (b == "8" && two) return 30;
			end
			"j": if (b == "p" && two) return 25;
			"k": if (b >= "0" && b <= "1" && two) return b - "0" + 26;
			"g": if (b == "p" && two) return 28;
			"f": if (b == "p" && two) return 30;
			"r": begin
				if (b == "a" && two) return 31;
				if (is_dec(b)) begin
					if (two) return b - "0";
					if (is_dec(c) && n == 3) begin
						v = (b - "0") * 10 + (c - "0");
						if (v < 32) return v;
					end
				end
			end
			"p": if (b == "c" && two) return 32;
			default: ;
		endcase
		return -1;
	endfunction

	// Returns 1 when the character that ended the word was used up by it.
	function automatic bit close_word(logic [7:0] c);
		int r;
		lex_mode = mct_pkg::M_IDLE;
		if (text_len == 1 && c == ":") begin
			for (int k = 0; k < 14; k++)
				if (MOD_CHARS[k] == text_buf[0]) begin
					push_token(mct_pkg::K_MOD0 + 5'(k), 64'd0, 8'd0, 1'b1);
					return 1'b1;
				end
			push_token(mct_pkg::K_BAD, 64'd0, 8'd0, 1'b1);
			return 1'b1;
		end
		if (is_dec(text_buf[0])) begin
			push_number(text_len);
			return 1'b0;
		end
		r = mips_reg(text_len);
		if (r >= 0) push_token(mct_pkg::K_REG, 64'(r), 8'd0, 1'b1);
		else push_text_run(mct_pkg::K_WORD, text_len);
		return 1'b0;
	endfunction

	function automatic void open_token(logic [7:0] c);
		if (swallow_line) begin
			if (c == 8'd0) swallow_line = 0;
			return;
		end
		if (c == " " || c == 8'd9 || c == 8'd10) return;
		if (c == 8'd0 || c == "#") begin
			push_token(mct_pkg::K_EOL, 64'd0, 8'd0, 1'b1);
			if (c == "#") swallow_line = 1;
			return;
		end
		if (c == "\"" || c == "'") begin
			lex_mode = mct_pkg::M_QUOTE;
			in_char_const = (c == "'");
			text_len = 0;
			return;
		end
		for (int k = 0; k < 22; k += 2)
			if (OPER_PAIRS[k] == c) begin
				held_ch = c;
				lex_mode = mct_pkg::M_OPER;
				return;
			end
		if (is_word_ch(c)) begin
			text_buf[0] = c;
			text_len = 1;
			lex_mode = mct_pkg::M_WORD;
			return;
		end
		push_token(mct_pkg::K_SINGLE, 64'(c), 8'd0, 1'b1);
	endfunction

	// A character that closes a token by look-ahead is looked at again as a fresh start.
	function automatic void take_char(logic [7:0] c);
		bit again, hit;
		logic [7:0] b;
		words_this_char = 0;
		for (int pass = 0; pass < 4; pass++) begin
			again = 0;
			case (lex_mode)
				mct_pkg::M_OPER: begin
					hit = 0;
					lex_mode = mct_pkg::M_IDLE;
					for (int k = 0; k < 11; k++)
						if (!hit && OPER_PAIRS[2 * k] == held_ch
							&& OPER_PAIRS[2 * k + 1] == c) begin
							push_token(mct_pkg::K_OP0 + 5'(k), 64'd0, 8'd0, 1'b1);
							hit = 1;
						end
					if (!hit) begin
						push_token(mct_pkg::K_SINGLE, 64'(held_ch), 8'd0, 1'b1);
						again = 1;
					end
				end
				mct_pkg::M_WORD: begin
					if (is_word_ch(c)) begin
						text_buf[text_len % mct_pkg::BUF_DEPTH] = c;
						text_len++;
						if (text_len >= mct_pkg::MAX_TEXT) begin
							push_token(mct_pkg::K_BAD, 64'd0, 8'd0, 1'b1);
							swallow_line = 1;
							lex_mode = mct_pkg::M_IDLE;
						end
					end else begin
						again = !close_word(c);
					end
				end
				mct_pkg::M_QUOTE: begin
					if (c == 8'd0) begin
						close_quote();
						again = 1;
					end else if (c == (in_char_const ? 8'h27 : 8'h22)) begin
						close_quote();
					end else if (c == "\\") begin
						lex_mode = mct_pkg::M_QESC;
					end else begin
						void'(store_text(c));
					end
				end
				mct_pkg::M_QESC: begin
					lex_mode = mct_pkg::M_QUOTE;
					if (c == 8'd0) begin
						if (!store_text(8'd0)) close_quote();
						again = 1;
					end else if (c >= "0" && c <= "7") begin
						oct_val = 9'(c - "0");
						oct_digits = 1;
						lex_mode = mct_pkg::M_QOCT;
					end else begin
						case (c)
							"b": b = 8'd8;
							"t": b = 8'd9;
							"n": b = 8'd10;
							"f": b = 8'd12;
							"r": b = 8'd13;
							default: b = c;
						endcase
						void'(store_text(b));
					end
				end
				mct_pkg::M_QOCT: begin
					lex_mode = mct_pkg::M_QUOTE;
					if (c >= "0" && c <= "7" && oct_digits < 3) begin
						oct_val = 9'(oct_val * 8 + (c - "0"));
						oct_digits++;
						if (oct_digits >= 3) void'(store_text(oct_val[7:0]));
						else lex_mode = mct_pkg::M_QOCT;
					end else begin
						void'(store_text(oct_val[7:0]));
						again = 1;
					end
				end
				default: begin
					lex_mode = mct_pkg::M_IDLE;
					open_token(c);
				end
			endcase
			if (!again) break;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_word_t want;
		if (!arst_n) begin
			token_q.delete();
			lex_mode = mct_pkg::M_IDLE;
			text_len = 0;
			in_char_const = 0;
			oct_digits = 0;
			oct_val = '0;
			held_ch = '0;
			swallow_line = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (tok.valid && tok.ready) begin
				if (token_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: token word kind=%0d value=%0h char=%0h last=%0b %s",
							$realtime, tok.kind, tok.value, tok.text_char, tok.last,
							"with none awaited");
				end else begin
					want = token_q.pop_front();
					if (tok.kind !== want.kind || tok.value !== want.value ||
						tok.text_char !== want.text_char || tok.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: token word mismatch: kind %0d/%0d value %0h/%0h ",
								"char %0h/%0h last %0b/%0b (awaited/seen)"},
								$realtime, want.kind, tok.kind, want.value, tok.value,
								want.text_char, tok.text_char, want.last, tok.last);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				take_char(cmd.ch);
			pending = token_q.size();
		end
	end

endmodule

FILE: bench/monitor_command_tokenizer_core_tb.sv
// Top of the tokenizer bench: clock, reset, command line stimulus, token sink and verdict.
`timescale 1ns / 1ps
module monitor_command_tokenizer_core_tb;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;

	mct_cmd_if cmd_if ();
	mct_tok_if tok_if ();

	monitor_command_tokenizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if.sink),
		.tok    (tok_if.source)
	);

	mct_token_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_if),
		.tok        (tok_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Characters of the line being built, sent in order with the terminating 0 included.
	logic [7:0] line_q[$];
	int         chars_sent;
	bit         steady_source;
	bit         steady_sink;
	bit         hold_request;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// A run that hangs, for instance on a result that never comes, ends here.
	initial begin
		#8ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// The token sink. Each word waits a random number of cycles before ready is raised, or
	// none while the sink is steady, and once the stimulus asks for it the sink holds off for a
	// long stretch so that the output register and then the character channel back up.
	initial begin
		int wait_cycles;
		tok_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				tok_if.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_request = 0;
			end
			wait_cycles = steady_sink ? 0 : $urandom_range(0, 11);
			if (wait_cycles > 0) begin
				tok_if.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			tok_if.ready <= 1'b1;
			do @(posedge clk); while (!(tok_if.valid && tok_if.ready));
		end
	end

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	// Sends one word on the character channel. Valid stays high between back-to-back
	// words and is only lowered when a gap is drawn.
	task automatic send_char(logic [7:0] c);
		int wait_cycles;
		wait_cycles = steady_source ? 0 : $urandom_range(0, 11);
		if (wait_cycles > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (wait_cycles) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.ch    <= c;
		do @(posedge clk); while (!cmd_if.ready);
		chars_sent++;
	endtask

	task automatic send_line();
		while (line_q.size() > 0)
			send_char(line_q.pop_front());
	endtask

	function automatic logic [7:0] pick_letter();
		string letters;
		letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
		return letters[$urandom_range(0, letters.len() - 1)];
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return 8'd9;
			1: return 8'd10;
			default: return " ";
		endcase
	endfunction

	// Appends one token of random form and content to the line.
	task automatic add_token();
		string regs[15];
		string digits;
		int n;
		regs = '{"r5", "r31", "r32", "sp", "ta2", "t9", "pc", "AT", "k1", "fp", "gp", "jp",
			"a7", "v1", "s8"};
		case ($urandom_range(0, 11))
			0, 1: begin
				digits = "0123456789abcdefABCDEF";
				case ($urandom_range(0, 3))
					0: put_text("0x");
					1: put_text("0");
					default: ;
				endcase
				n = ($urandom_range(0, 9) == 0) ? 22 : $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					line_q.push_back(digits[$urandom_range(0, 9 + 12 * (i & 1))]);
				case ($urandom_range(0, 5))
					0: put_text("K");
					1: put_text("m");
					2: put_text("G");
					3: put_text("q");
					default: ;
				endcase
			end
			2: begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					line_q.push_back(pick_letter());
			end
			3: put_text(regs[$urandom_range(0, 14)]);
			4, 5: begin
				line_q.push_back(($urandom_range(0, 1) == 0) ? 8'h22 : 8'h27);
				n = $urandom_range(0, 10);
				for (int i = 0; i < n; i++)
					case ($urandom_range(0, 5))
						0: put_text("\\n");
						1: put_text("\\377");
						2: put_text("\\6");
						3: line_q.push_back(8'($urandom_range(1, 255)));
						default: line_q.push_back(pick_letter());
					endcase
				line_q.push_back(($urandom_range(0, 3) == 0) ? 8'h27 : 8'h22);
			end
			6: begin
				digits = "<=>!+-&|$f";
				line_q.push_back(digits[$urandom_range(0, 9)]);
				line_q.push_back(digits[$urandom_range(0, 9)]);
			end
			7: begin
				digits = "hsLPE";
				line_q.push_back(($urandom_range(0, 3) == 0) ? pick_letter()
					: digits[$urandom_range(0, 4)]);
				put_text(":");
			end
			8: line_q.push_back(8'($urandom_range(1, 255)));
			9: put_text("# rest is ignored");
			10: begin
				// Overlong text: a word that fills the buffer, or quoted text that does.
				if ($urandom_range(0, 1) == 0) begin
					for (int i = 0; i < 33; i++)
						line_q.push_back(pick_letter());
				end else begin
					put_text("'");
					for (int i = 0; i < 34; i++)
						line_q.push_back(pick_letter());
				end
			end
			default: line_q.push_back(pick_letter());
		endcase
	endtask

	initial begin
		int tokens;
		bit did_hold, did_pause;
		arst_n        = 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.ch    <= 8'd0;
		chars_sent    = 0;
		steady_source = 0;
		steady_sink   = 0;
		hold_request  = 0;
		did_hold      = 0;
		did_pause     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lines: end of line, a comment, escapes, a packed constant, numbers in each
		// base, one with a suffix, operators, modifiers good and bad, a register and a high byte.
		line_q.push_back(8'd0);
		put_text("#ab");
		line_q.push_back(8'd0);
		put_text("\"a\\n\\101\\q\"'AB'");
		line_q.push_back(8'd0);
		put_text("0x1fK 017 9<=!=$f h:z:r31 ");
		line_q.push_back(8'hFF);
		line_q.push_back(8'd0);
		send_line();

		// Random lines of well-formed tokens, mostly with blanks between them, and some noise.
		while (chars_sent < 200) begin
			steady_source = ($urandom_range(0, 3) == 0);
			steady_sink   = ($urandom_range(0, 3) == 0);
			tokens = $urandom_range(1, 5);
			for (int t = 0; t < tokens; t++) begin
				add_token();
				if ($urandom_range(0, 2) != 0) line_q.push_back(pick_blank());
			end
			line_q.push_back(8'd0);
			if (!did_hold && chars_sent > 90) begin
				hold_request = 1;
				did_hold = 1;
			end
			send_line();
			if (!did_pause && chars_sent > 150) begin
				// Hold the source back until the tokenizer has drained completely.
				cmd_if.valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				repeat (100) @(posedge clk);
				did_pause = 1;
			end
		end
		cmd_if.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/mct_pkg.sv
rtl/mct_if.sv
rtl/mct_ram.sv
rtl/monitor_command_tokenizer_core.sv
bench/mct_token_checker.sv
bench/monitor_command_tokenizer_core_tb.sv
